/* rtl/esp_fit_pkg.sv */
package esp_fit_pkg;

    localparam int DEF_MAX_CENTERS = 16;
    localparam int CNT_W           = 5;
    localparam int IDX_XW          = 8;
    localparam int COORD_W         = 32;
    localparam int Y_W             = 32;
    localparam int DIST_W          = 64;
    localparam int ACC_W           = 64;
    localparam int P_W             = 91;
    localparam int QS_W            = 128;
    localparam int RS_W            = 126;
    localparam int CAND_W          = 130;
    localparam int BIT_W           = 5;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_POINT  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_READ_A = 3'd3,
        OP_READ_B = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_SAT    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIST,
        ST_DRAIN_D,
        ST_ROOT,
        ST_SNAP,
        ST_MAC,
        ST_DRAIN_M,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] potential;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] read_value;
        logic [1:0]         status;
    } t_out_item;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic             load_r;
        logic             root_init;
        logic             root_step;
        logic [BIT_W-1:0] bit_idx;
        logic             snap;
        logic             ring_fwd;
        logic             ring_back;
        logic             row_shift;
    } t_cell_ctl;

endpackage

/* rtl/esp_fit_cell.sv */
module esp_fit_cell (
    input  logic                   i_clk,
    input  esp_fit_pkg::t_cell_ctl i_ctl,
    input  logic [63:0]            i_r_prev,
    output logic [63:0]            o_r,
    input  logic [31:0]            i_y_next,
    input  logic [31:0]            i_y_prev,
    output logic [31:0]            o_y,
    input  logic [31:0]            i_yr_next,
    output logic [31:0]            o_yr
);
    import esp_fit_pkg::*;

    localparam logic [CAND_W-1:0] LIMIT = CAND_W'(1) << 90;

    logic [DIST_W-1:0] r_r;
    logic [P_W-1:0]    r_p;
    logic [QS_W-1:0]   r_qs;
    logic [RS_W-1:0]   r_rs;
    logic [Y_W-1:0]    r_y;
    logic [Y_W-1:0]    r_yr;
    logic [CAND_W-1:0] w_cand;
    logic              w_take;
    logic [Y_W-1:0]    w_mask;

    // candidate t = y | bit: t^2 R = y^2 R + y R 2^(b+1) + R 4^b, kept pre-shifted
    assign w_cand = CAND_W'(r_p) + CAND_W'(r_qs) + CAND_W'(r_rs);
    assign w_take = (w_cand <= LIMIT);
    assign w_mask = Y_W'(1) << i_ctl.bit_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_r) begin
            r_r <= i_r_prev;
        end
        if (i_ctl.root_init) begin
            r_p  <= '0;
            r_qs <= '0;
            r_rs <= {r_r, 62'b0};
            r_y  <= '0;
        end else if (i_ctl.root_step) begin
            if (w_take) begin
                r_p  <= w_cand[P_W-1:0];
                r_y  <= r_y | w_mask;
                r_qs <= (r_qs >> 1) + QS_W'(r_rs);
            end else begin
                r_qs <= r_qs >> 1;
            end
            r_rs <= r_rs >> 2;
        end else if (i_ctl.ring_fwd) begin
            r_y <= i_y_next;
        end else if (i_ctl.ring_back) begin
            r_y <= i_y_prev;
        end
        if (i_ctl.snap) begin
            r_yr <= r_y;
        end else if (i_ctl.row_shift) begin
            r_yr <= i_yr_next;
        end
    end

    assign o_r  = r_r;
    assign o_y  = r_y;
    assign o_yr = r_yr;

endmodule

/* rtl/esp_fit_accmem.sv */
module esp_fit_accmem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [63:0]       o_rd_data,
    input  logic              i_add_en,
    input  logic [AW-1:0]     i_add_addr,
    input  logic              i_old_valid,
    input  logic [63:0]       i_term,
    output logic              o_sat
);
    import esp_fit_pkg::*;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic [ACC_W-1:0] mem [DEPTH];
    logic [ACC_W-1:0] r_rd;
    logic [ACC_W-1:0] r_rd_d;
    logic [ACC_W-1:0] w_old;
    logic [ACC_W:0]   w_sum;
    logic             w_ovf;
    logic [ACC_W-1:0] w_new;

    // entry never written since clear reads as zero
    assign w_old = i_old_valid ? r_rd_d : '0;
    assign w_sum = {w_old[ACC_W-1], w_old} + {i_term[ACC_W-1], i_term};
    assign w_ovf = w_sum[ACC_W] ^ w_sum[ACC_W-1];
    assign w_new = w_ovf ? (w_sum[ACC_W] ? ACC_MIN : ACC_MAX) : w_sum[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
        r_rd_d <= r_rd;
        if (i_add_en) begin
            mem[i_add_addr] <= w_new;
        end
    end

    assign o_rd_data = r_rd;
    assign o_sat     = i_add_en & w_ovf;

endmodule

/* rtl/esp_fit_normal_equation_accumulator_unit.sv */
// Least-squares normal-equation accumulator for point-charge fitting to
// electrostatic potential samples. Load centers with op 0, then send one
// item per surface point (op 1); each point adds V/r_k to B[k] and
// 1/(r_j r_k) to the lower triangle of A for all pairs j <= k of the
// first n centers, n = num_centers clipped to MAX_CENTERS. Op 2 clears A,
// B and the sticky saturation flag, ops 3 and 4 read A(row,col) and
// B(row) as signed Q32.32. Every item gives exactly one result item.
// Timing: one item at a time. A point streams the centers through the
// distance pipeline, runs the bitwise inverse square root in all cells at
// once, then walks the n(n+1)/2 matrix pairs, one pair per cycle through
// the single pair multiplier, and finally drains the pair pipeline. The
// pair loop walks a ring of cells back and forth so each row costs only
// its own length. A point that lands exactly on a center is rejected
// before any update. A result waits in an output register, so the next
// item is taken while the previous result is still unclaimed.
module esp_fit_normal_equation_accumulator_unit #(
    parameter int MAX_CENTERS = esp_fit_pkg::DEF_MAX_CENTERS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  esp_fit_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output esp_fit_pkg::t_out_item o_out_item,
    input  logic                   i_cfg_we,
    input  logic [esp_fit_pkg::CNT_W-1:0] i_cfg_data
);
    import esp_fit_pkg::*;

    localparam int AW  = $clog2(MAX_CENTERS);
    localparam int NW  = $clog2(MAX_CENTERS + 1);
    localparam int TRI = MAX_CENTERS * (MAX_CENTERS + 1) / 2;
    localparam int TW  = $clog2(TRI);

    // control state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_num_centers;
    logic                  r_out_valid;
    t_out_item             r_out_item;
    t_in_item              r_item;
    logic                  r_sat_flag;
    logic [MAX_CENTERS-1:0] r_row_valid;  // triangle row k written since clear
    logic [MAX_CENTERS-1:0] r_vec_valid;
    logic                  r_reject;
    logic                  r_pt_sat;
    logic [63:0]           r_res_value;
    logic [1:0]            r_res_status;
    logic                  r_rd_fresh;

    // counters
    logic [AW-1:0]         r_cnt;
    logic [BIT_W-1:0]      r_bit;
    logic [AW-1:0]         r_k;
    logic [AW-1:0]         r_j;
    logic [TW-1:0]         r_base;
    logic                  r_first;

    // center stores
    logic [31:0]           mem_cx [MAX_CENTERS];
    logic [31:0]           mem_cy [MAX_CENTERS];
    logic [31:0]           mem_cz [MAX_CENTERS];
    logic [31:0]           r_cx_q, r_cy_q, r_cz_q;

    // distance pipeline
    logic                  r_d1_valid, r_d2_valid, r_d3_valid;
    logic [31:0]           r_mx, r_my, r_mz;
    logic                  r_d2_zero, r_d3_zero;
    logic [61:0]           r_sx, r_sy, r_sz;
    logic [32:0]           w_dx, w_dy, w_dz;
    logic [31:0]           w_mx, w_my, w_mz;
    logic [63:0]           w_qx, w_qy, w_qz;
    logic [DIST_W-1:0]     w_r_new;

    // pair pipeline
    logic                  r_m1_valid, r_m2_valid;
    logic                  r_m1_first, r_m2_first;
    logic                  r_m1_fa, r_m2_fa, r_m1_fb, r_m2_fb;
    logic [AW-1:0]         r_m1_k, r_m2_k;
    logic [TW-1:0]         r_m1_idx, r_m2_idx;
    logic [63:0]           r_pa, r_pb;
    logic [63:0]           r_ta, r_tb;
    logic [31:0]           w_vmag;
    logic [49:0]           w_bmag;
    logic [63:0]           w_ta, w_tb;

    // cells
    logic [DIST_W-1:0]     w_cell_r  [MAX_CENTERS];
    logic [Y_W-1:0]        w_cell_y  [MAX_CENTERS];
    logic [Y_W-1:0]        w_cell_yr [MAX_CENTERS];
    t_cell_ctl             w_ctl;

    // misc decode
    logic                  w_in_acc;
    logic [IDX_XW-1:0]     w_n8, w_num8, w_max8, w_act8, w_row8, w_col8, w_hi8;
    logic [NW-1:0]         w_n;
    logic [NW-1:0]         w_n_m1;
    logic [AW-1:0]         w_last;
    logic [3:0]            w_hi, w_lo;
    logic [15:0]           w_tri16;
    logic [TW-1:0]         w_tri;
    logic [MAX_CENTERS-1:0] w_act_mask;
    logic                  w_row_end;
    logic                  w_dist_empty, w_mac_empty;

    // accumulator ports
    logic                  w_a_rd_en, w_b_rd_en;
    logic [TW-1:0]         w_a_rd_addr;
    logic [AW-1:0]         w_b_rd_addr;
    logic [63:0]           w_a_rd_data, w_b_rd_data;
    logic                  w_a_sat, w_b_sat;

    // strobes from the output decoder
    logic                  s_load_wr, s_clear, s_rd_a, s_rd_b, s_dist_issue;
    logic                  s_mac_issue, s_finish, s_res_set, s_out_load, s_point_go;
    logic [63:0]           n_res_value;
    logic [1:0]            n_res_status;

    assign w_in_acc   = i_in_valid & o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // active center count, clipped to the store depth
    assign w_num8 = IDX_XW'(r_num_centers);
    assign w_max8 = IDX_XW'(MAX_CENTERS);
    assign w_act8 = (w_num8 > w_max8) ? w_max8 : w_num8;
    assign w_n    = w_act8[NW-1:0];
    assign w_n8   = IDX_XW'(w_n);
    assign w_n_m1 = w_n - NW'(1);
    assign w_last = w_n_m1[AW-1:0];
    assign w_row8 = IDX_XW'(r_item.row_index);
    assign w_col8 = IDX_XW'(r_item.col_index);

    // A is stored as its lower triangle, (lo,hi) at hi(hi+1)/2 + lo
    assign w_hi    = (r_item.row_index < r_item.col_index) ? r_item.col_index
                                                           : r_item.row_index;
    assign w_lo    = (r_item.row_index < r_item.col_index) ? r_item.row_index
                                                           : r_item.col_index;
    assign w_hi8   = IDX_XW'(w_hi);
    assign w_tri16 = 16'((16'(w_hi) * (16'(w_hi) + 16'd1)) >> 1) + 16'(w_lo);
    assign w_tri   = w_tri16[TW-1:0];

    always_comb begin
        for (int i = 0; i < MAX_CENTERS; i++) begin
            w_act_mask[i] = (IDX_XW'(i) < w_n8);
        end
    end

    // zigzag: odd rows walk j upward, even rows walk j downward
    assign w_row_end    = r_k[0] ? (r_j == r_k) : (r_j == '0);
    assign w_dist_empty = !(r_d1_valid || r_d2_valid || r_d3_valid);
    assign w_mac_empty  = !(r_m1_valid || r_m2_valid);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (r_item.op)
                    OP_POINT: begin
                        n_state = (w_n == '0) ? ST_DONE : ST_DIST;
                    end
                    OP_READ_A: begin
                        n_state = (w_row8 >= w_n8 || w_col8 >= w_n8) ? ST_DONE : ST_READ;
                    end
                    OP_READ_B: begin
                        n_state = (w_row8 >= w_n8) ? ST_DONE : ST_READ;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DIST: begin
                if (r_cnt == '0) begin
                    n_state = ST_DRAIN_D;
                end
            end
            ST_DRAIN_D: begin
                if (w_dist_empty) begin
                    n_state = r_reject ? ST_DONE : ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_bit == '0) begin
                    n_state = ST_SNAP;
                end
            end
            ST_SNAP: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                if (w_row_end && r_k == w_last) begin
                    n_state = ST_DRAIN_M;
                end
            end
            ST_DRAIN_M: begin
                if (w_mac_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_load_wr    = 1'b0;
        s_clear      = 1'b0;
        s_rd_a       = 1'b0;
        s_rd_b       = 1'b0;
        s_dist_issue = 1'b0;
        s_mac_issue  = 1'b0;
        s_finish     = 1'b0;
        s_res_set    = 1'b0;
        s_out_load   = 1'b0;
        s_point_go   = 1'b0;
        n_res_value  = '0;
        n_res_status = STAT_OK;
        w_ctl        = '0;
        w_ctl.load_r = r_d3_valid;
        case (r_state)
            ST_DECODE: begin
                s_res_set = 1'b1;
                case (r_item.op)
                    OP_LOAD: begin
                        if (w_row8 >= w_max8) begin
                            n_res_status = STAT_RANGE;
                        end else begin
                            s_load_wr = 1'b1;
                        end
                    end
                    OP_POINT: begin
                        s_point_go = (w_n != '0);
                    end
                    OP_CLEAR: begin
                        s_clear = 1'b1;
                    end
                    OP_READ_A: begin
                        if (w_row8 >= w_n8 || w_col8 >= w_n8) begin
                            n_res_status = STAT_RANGE;
                        end else begin
                            s_rd_a = 1'b1;
                        end
                    end
                    OP_READ_B: begin
                        if (w_row8 >= w_n8) begin
                            n_res_status = STAT_RANGE;
                        end else begin
                            s_rd_b = 1'b1;
                        end
                    end
                    default: begin
                        n_res_status = STAT_OK;
                    end
                endcase
            end
            ST_DIST: begin
                s_dist_issue = 1'b1;
            end
            ST_DRAIN_D: begin
                if (w_dist_empty) begin
                    if (r_reject) begin
                        s_res_set    = 1'b1;
                        n_res_status = STAT_REJECT;
                    end else begin
                        w_ctl.root_init = 1'b1;
                    end
                end
            end
            ST_ROOT: begin
                w_ctl.root_step = 1'b1;
                w_ctl.bit_idx   = r_bit;
            end
            ST_SNAP: begin
                w_ctl.snap = 1'b1;
            end
            ST_MAC: begin
                s_mac_issue = 1'b1;
                if (!w_row_end) begin
                    w_ctl.ring_fwd  = r_k[0];
                    w_ctl.ring_back = !r_k[0];
                end else if (r_k != w_last) begin
                    w_ctl.row_shift = 1'b1;
                    w_ctl.ring_fwd  = r_k[0];
                end
            end
            ST_DRAIN_M: begin
                if (w_mac_empty) begin
                    s_finish     = 1'b1;
                    s_res_set    = 1'b1;
                    n_res_status = r_pt_sat ? STAT_SAT : STAT_OK;
                end
            end
            ST_READ: begin
                s_res_set    = 1'b1;
                n_res_status = r_sat_flag ? STAT_SAT : STAT_OK;
                if (r_rd_fresh) begin
                    n_res_value = (r_item.op == OP_READ_A) ? w_a_rd_data : w_b_rd_data;
                end
            end
            ST_DONE: begin
                s_out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                s_out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_num_centers <= CNT_W'(1);
            r_out_valid   <= 1'b0;
            r_sat_flag    <= 1'b0;
            r_row_valid   <= '0;
            r_vec_valid   <= '0;
            r_d1_valid    <= 1'b0;
            r_d2_valid    <= 1'b0;
            r_d3_valid    <= 1'b0;
            r_m1_valid    <= 1'b0;
            r_m2_valid    <= 1'b0;
            r_reject      <= 1'b0;
            r_pt_sat      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num_centers <= i_cfg_data;
            end
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s_clear) begin
                r_sat_flag  <= 1'b0;
                r_row_valid <= '0;
                r_vec_valid <= '0;
            end else if (s_finish) begin
                r_sat_flag  <= r_sat_flag | r_pt_sat;
                r_row_valid <= r_row_valid | w_act_mask;
                r_vec_valid <= r_vec_valid | w_act_mask;
            end
            r_d1_valid <= s_dist_issue;
            r_d2_valid <= r_d1_valid;
            r_d3_valid <= r_d2_valid;
            r_m1_valid <= s_mac_issue;
            r_m2_valid <= r_m1_valid;
            if (w_in_acc) begin
                r_reject <= 1'b0;
                r_pt_sat <= 1'b0;
            end else begin
                if (r_d3_valid) begin
                    r_reject <= r_reject | r_d3_zero;
                end
                r_pt_sat <= r_pt_sat | w_a_sat | w_b_sat;
            end
        end
    end

    // sequencer counters and payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_item;
        end
        if (s_res_set) begin
            r_res_value  <= n_res_value;
            r_res_status <= n_res_status;
        end
        if (s_out_load) begin
            r_out_item.read_value <= r_res_value;
            r_out_item.status     <= r_res_status;
        end
        if (s_rd_a) begin
            r_rd_fresh <= r_row_valid[w_hi8[AW-1:0]];
        end else if (s_rd_b) begin
            r_rd_fresh <= r_vec_valid[w_row8[AW-1:0]];
        end
        if (s_point_go) begin
            r_cnt <= w_last;
        end else if (s_dist_issue) begin
            r_cnt <= r_cnt - AW'(1);
        end
        if (w_ctl.root_init) begin
            r_bit <= BIT_W'(Y_W - 1);
        end else if (w_ctl.root_step) begin
            r_bit <= r_bit - BIT_W'(1);
        end
        if (w_ctl.snap) begin
            r_k     <= '0;
            r_j     <= '0;
            r_base  <= '0;
            r_first <= 1'b1;
        end else if (s_mac_issue) begin
            if (!w_row_end) begin
                r_j     <= r_k[0] ? r_j + AW'(1) : r_j - AW'(1);
                r_first <= 1'b0;
            end else begin
                r_k     <= r_k + AW'(1);
                r_j     <= r_k[0] ? r_k + AW'(1) : '0;
                r_base  <= r_base + TW'(r_k) + TW'(1);
                r_first <= 1'b1;
            end
        end
    end

    // center stores, walked from the top index down so cell k ends with center k
    always_ff @(posedge i_clk) begin
        if (s_load_wr) begin
            mem_cx[w_row8[AW-1:0]] <= r_item.pos_x;
            mem_cy[w_row8[AW-1:0]] <= r_item.pos_y;
            mem_cz[w_row8[AW-1:0]] <= r_item.pos_z;
        end
        if (s_dist_issue) begin
            r_cx_q <= mem_cx[r_cnt];
            r_cy_q <= mem_cy[r_cnt];
            r_cz_q <= mem_cz[r_cnt];
        end
    end

    // distance pipeline: difference, square, quarter-sum
    assign w_dx = {r_item.pos_x[31], r_item.pos_x} - {r_cx_q[31], r_cx_q};
    assign w_dy = {r_item.pos_y[31], r_item.pos_y} - {r_cy_q[31], r_cy_q};
    assign w_dz = {r_item.pos_z[31], r_item.pos_z} - {r_cz_q[31], r_cz_q};
    assign w_mx = w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
    assign w_my = w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
    assign w_mz = w_dz[32] ? 32'(-w_dz) : w_dz[31:0];
    assign w_qx = 64'(r_mx) * 64'(r_mx);
    assign w_qy = 64'(r_my) * 64'(r_my);
    assign w_qz = 64'(r_mz) * 64'(r_mz);
    assign w_r_new = DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);

    always_ff @(posedge i_clk) begin
        r_mx      <= w_mx;
        r_my      <= w_my;
        r_mz      <= w_mz;
        r_d2_zero <= (w_dx == '0) && (w_dy == '0) && (w_dz == '0);
        r_sx      <= w_qx[63:2];
        r_sy      <= w_qy[63:2];
        r_sz      <= w_qz[63:2];
        r_d3_zero <= r_d2_zero;
    end

    // row of cells: R enters at cell 0, y values circulate as a ring
    for (genvar gi = 0; gi < MAX_CENTERS; gi++) begin : g_cell
        localparam int NXT = (gi + 1) % MAX_CENTERS;
        localparam int PRV = (gi + MAX_CENTERS - 1) % MAX_CENTERS;
        logic [DIST_W-1:0] w_prev_r;
        if (gi == 0) begin : g_head
            assign w_prev_r = w_r_new;
        end else begin : g_body
            assign w_prev_r = w_cell_r[gi-1];
        end
        esp_fit_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_r_prev  (w_prev_r),
            .o_r       (w_cell_r[gi]),
            .i_y_next  (w_cell_y[NXT]),
            .i_y_prev  (w_cell_y[PRV]),
            .o_y       (w_cell_y[gi]),
            .i_yr_next (w_cell_yr[NXT]),
            .o_yr      (w_cell_yr[gi])
        );
    end

    // pair products: ring head is y_j, row-copy head is y_k
    assign w_vmag = r_item.potential[31] ? 32'(-r_item.potential) : 32'(r_item.potential);
    assign w_bmag = 50'((r_pb + 64'd8192) >> 14);
    assign w_tb   = r_item.potential[31] ? 64'(-64'(w_bmag)) : 64'(w_bmag);
    assign w_ta   = 64'(r_pa[63:28]) + 64'(r_pa[27]);

    always_ff @(posedge i_clk) begin
        r_pa       <= 64'(w_cell_y[0]) * 64'(w_cell_yr[0]);
        r_pb       <= 64'(w_vmag) * 64'(w_cell_yr[0]);
        r_m1_first <= r_first;
        r_m1_k     <= r_k;
        r_m1_idx   <= r_base + TW'(r_j);
        r_m1_fa    <= r_row_valid[r_k];
        r_m1_fb    <= r_vec_valid[r_k];
        r_ta       <= w_ta;
        r_tb       <= w_tb;
        r_m2_first <= r_m1_first;
        r_m2_k     <= r_m1_k;
        r_m2_idx   <= r_m1_idx;
        r_m2_fa    <= r_m1_fa;
        r_m2_fb    <= r_m1_fb;
    end

    assign w_a_rd_en   = s_rd_a | s_mac_issue;
    assign w_a_rd_addr = s_rd_a ? w_tri : (r_base + TW'(r_j));
    assign w_b_rd_en   = s_rd_b | (s_mac_issue & r_first);
    assign w_b_rd_addr = s_rd_b ? w_row8[AW-1:0] : r_k;

    esp_fit_accmem #(
        .DEPTH (TRI),
        .AW    (TW)
    ) u_mat (
        .i_clk       (i_clk),
        .i_rd_en     (w_a_rd_en),
        .i_rd_addr   (w_a_rd_addr),
        .o_rd_data   (w_a_rd_data),
        .i_add_en    (r_m2_valid),
        .i_add_addr  (r_m2_idx),
        .i_old_valid (r_m2_fa),
        .i_term      (r_ta),
        .o_sat       (w_a_sat)
    );

    esp_fit_accmem #(
        .DEPTH (MAX_CENTERS),
        .AW    (AW)
    ) u_vec (
        .i_clk       (i_clk),
        .i_rd_en     (w_b_rd_en),
        .i_rd_addr   (w_b_rd_addr),
        .o_rd_data   (w_b_rd_data),
        .i_add_en    (r_m2_valid & r_m2_first),
        .i_add_addr  (r_m2_k),
        .i_old_valid (r_m2_fb),
        .i_term      (r_tb),
        .o_sat       (w_b_sat)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // pair walk stays inside the lower triangle
    a_pair_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_j <= r_k))
        else $error("pair walk left the lower triangle");

    a_pair_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> ((32'(r_base) + 32'(r_j)) < 32'(TRI)))
        else $error("matrix address out of range");

    a_root_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> !(w_ctl.ring_fwd || w_ctl.ring_back || w_ctl.load_r))
        else $error("ring moved during root iteration");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("second item taken while busy");

    a_sat_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_a_sat || w_b_sat) |-> (r_state == ST_MAC || r_state == ST_DRAIN_M))
        else $error("saturation outside a point");

endmodule
